// ===== rtl/noto_pkg.sv =====
// Package for the note tone oscillator: request codes, payload widths,
// the phase step table and the quarter-wave sine table.
// Depends on nothing; every other file of the block imports it.
package noto_pkg;

  // Oscillator configuration.
  localparam int SampleRate  = 48000;
  localparam int SineEntries = 1024;
  localparam int PhaseBits   = 32;

  // Derived sizes.
  localparam int SineBits       = $clog2(SineEntries);
  localparam int QuarterBits    = SineBits - 1;
  localparam int QuarterEntries = SineEntries / 4 + 1;
  localparam int NoteCount      = 128;
  localparam int SampleBits     = 16;
  localparam int MagBits        = 15;
  localparam int AmpBits        = 15;

  localparam logic [QuarterBits-1:0] QuarterTurn = QuarterBits'(SineEntries / 4);

  // Volume and amplitude constants.
  localparam logic [6:0]         VolumeMax    = 7'd100;
  localparam logic [7:0]         AmpPerVolume = 8'd200;
  localparam logic [AmpBits-1:0] AmpMax       = AmpBits'(100 * 200);
  localparam logic [AmpBits-1:0] AmpReset     = AmpBits'(16000);
  localparam logic [6:0]         ResetNote    = 7'd69;

  // Polynomial coefficients for sin(pi/2 * t), Q30.
  localparam logic [63:0] Q30One = 64'd1073741824;
  localparam logic [63:0] PolyC1 = 64'd1686629713;
  localparam logic [63:0] PolyC3 = 64'd693598669;
  localparam logic [63:0] PolyC5 = 64'd85569305;
  localparam logic [63:0] PolyC7 = 64'd4858525;

  // Request codes.
  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqStart = 2'd1,
    ReqStop  = 2'd2
  } req_e;

  // One tick on its way from the voice to the output stage.
  typedef struct packed {
    logic                  active;
    logic                  neg;
    logic [MagBits-1:0]    rom;
    logic [AmpBits-1:0]    amp;
    logic signed [SampleBits-1:0] left;
    logic signed [SampleBits-1:0] right;
  } tick_t;

  typedef logic [NoteCount-1:0][PhaseBits-1:0] step_tab_t;
  typedef logic [QuarterEntries-1:0][MagBits-1:0] quarter_tab_t;
  typedef logic [11:0][31:0] octave_tab_t;

  // Lowest-octave note frequencies in Hz scaled by 2^24.
  localparam octave_tab_t OctaveBase = '{
    32'd258937088, 32'd244404066, 32'd230686720, 32'd217739269,
    32'd205518503, 32'd193983636, 32'd183096171, 32'd172819773,
    32'd163120144, 32'd153964914, 32'd145323527, 32'd137167144
  };

  // Rounded phase step of every note, worked out at elaboration.
  function automatic step_tab_t build_step_table();
    step_tab_t   tab;
    int          oct;
    int          semi;
    int          sh;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] step;
    for (int n = 0; n < NoteCount; n++) begin
      oct  = n / 12;
      semi = n % 12;
      sh   = oct + PhaseBits - 24;
      if (sh >= 0) begin
        num  = 64'(OctaveBase[semi]) << sh;
        step = (num + 64'(SampleRate / 2)) / 64'(SampleRate);
      end else begin
        // Dividing by the shifted rate equals dividing by the rate, then shifting.
        den  = 64'(SampleRate) << (-sh);
        step = ((64'(OctaveBase[semi]) + (den >> 1)) / 64'(SampleRate)) >> (-sh);
      end
      tab[n] = step[PhaseBits-1:0];
    end
    return tab;
  endfunction

  // Quarter-wave sine magnitudes in Q15, from a truncated Q30 polynomial.
  function automatic quarter_tab_t build_quarter_table();
    quarter_tab_t tab;
    logic [63:0]  t;
    logic [63:0]  t2;
    logic [63:0]  p;
    logic [63:0]  s;
    logic [63:0]  r;
    for (int u = 0; u < QuarterEntries; u++) begin
      t  = (64'(u) << 32) / 64'(SineEntries);
      t2 = (t * t) >> 30;
      p  = PolyC7;
      p  = PolyC5 - ((p * t2) >> 30);
      p  = PolyC3 - ((p * t2) >> 30);
      p  = PolyC1 - ((p * t2) >> 30);
      s  = (p * t) >> 30;
      r  = (s * 64'd32767) >> 30;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      tab[u] = r[MagBits-1:0];
    end
    return tab;
  endfunction

  localparam step_tab_t    StepTable   = build_step_table();
  localparam quarter_tab_t SineQuarter = build_quarter_table();

endpackage

// ===== rtl/noto_req_if.sv =====
// Request channel of the note tone oscillator: valid/ready plus the
// request fields. Depends on noto_pkg for the field widths.
interface noto_req_if;
  import noto_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [6:0]                   note;
  logic [6:0]                   volume;
  logic signed [SampleBits-1:0] in_left;
  logic signed [SampleBits-1:0] in_right;

  modport source (output valid, req_type, note, volume, in_left, in_right, input ready);
  modport sink   (input valid, req_type, note, volume, in_left, in_right, output ready);
endinterface

// ===== rtl/noto_smp_if.sv =====
// Sample channel of the note tone oscillator: valid/ready plus the
// mixed stereo sample. Depends on noto_pkg for the field widths.
interface noto_smp_if;
  import noto_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] out_left;
  logic signed [SampleBits-1:0] out_right;
  logic                         tone_on;

  modport source (output valid, out_left, out_right, tone_on, input ready);
  modport sink   (input valid, out_left, out_right, tone_on, output ready);
endinterface

// ===== rtl/noto_voice.sv =====
// Voice of the note tone oscillator: phase accumulator, step, amplitude
// and the sine lookup, with the first pipeline register. Uses noto_pkg.
module noto_voice (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   fire_i,
  input  logic [1:0]                             req_type_i,
  input  logic [6:0]                             note_i,
  input  logic [6:0]                             volume_i,
  input  logic signed [noto_pkg::SampleBits-1:0] left_i,
  input  logic signed [noto_pkg::SampleBits-1:0] right_i,
  input  logic                                   load_i,
  output logic                                   valid_o,
  output noto_pkg::tick_t                        tick_o
);
  import noto_pkg::*;

  logic                   running_q, running_d;
  logic [PhaseBits-1:0]   phase_q, phase_d;
  logic [PhaseBits-1:0]   step_q, step_d;
  logic [AmpBits-1:0]     amp_q, amp_d;
  logic                   valid_q, valid_d;
  tick_t                  tick_q;
  logic                   is_tick;
  logic [6:0]             vol_sat;
  logic [SineBits-1:0]    index;
  logic [QuarterBits-1:0] rem;
  logic [QuarterBits-1:0] quarter_idx;

  // Volume saturates before it sets the amplitude.
  assign vol_sat = (volume_i > VolumeMax) ? VolumeMax : volume_i;

  // Request decoder and state update.
  always_comb begin
    running_d = running_q;
    phase_d   = phase_q;
    step_d    = step_q;
    amp_d     = amp_q;
    is_tick   = 1'b0;
    if (fire_i) begin
      unique case (req_e'(req_type_i))
        ReqStart: begin
          running_d = 1'b1;
          step_d    = StepTable[note_i];
          amp_d     = AmpBits'(vol_sat) * AmpBits'(AmpPerVolume);
          phase_d   = '0;
        end
        ReqStop: begin
          running_d = 1'b0;
        end
        ReqTick: begin
          is_tick = 1'b1;
          if (running_q) begin
            phase_d = phase_q + step_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Quarter-wave folding of the table index taken from the phase.
  assign index       = phase_q[PhaseBits-1 -: SineBits];
  assign rem         = {1'b0, index[SineBits-3:0]};
  assign quarter_idx = index[SineBits-2] ? (QuarterTurn - rem) : rem;

  // The first pipeline stage only takes ticks; other requests leave it empty.
  assign valid_d = load_i ? is_tick : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      phase_q   <= '0;
      step_q    <= StepTable[ResetNote];
      amp_q     <= AmpReset;
      valid_q   <= 1'b0;
    end else begin
      running_q <= running_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
      amp_q     <= amp_d;
      valid_q   <= valid_d;
    end
  end

  // Tick payload register.
  always_ff @(posedge clk_i) begin
    if (load_i && is_tick) begin
      tick_q.active <= running_q;
      tick_q.neg    <= index[SineBits-1];
      tick_q.rom    <= SineQuarter[quarter_idx];
      tick_q.amp    <= amp_q;
      tick_q.left   <= left_i;
      tick_q.right  <= right_i;
    end
  end

  assign valid_o = valid_q;
  assign tick_o  = tick_q;

  // A start always restarts the tone from phase zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_type_i == ReqStart) |=> (phase_q == '0) && running_q)
    else $error("start did not clear the phase or turn the tone on");

  // The amplitude stays within the saturated volume range.
  assert property (@(posedge clk_i) disable iff (!rst_ni) amp_q <= AmpMax)
    else $error("amplitude above the saturated maximum");

endmodule

// ===== rtl/noto_lane.sv =====
// One channel lane of the note tone oscillator: adds the tone sample to
// the channel sample with 16-bit wrap into the output register. Uses noto_pkg.
module noto_lane (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [noto_pkg::SampleBits-1:0] chan_i,
  input  logic signed [noto_pkg::SampleBits-1:0] tone_i,
  output logic signed [noto_pkg::SampleBits-1:0] sum_o
);
  import noto_pkg::*;

  logic signed [SampleBits-1:0] sum_q, sum_d;

  // Wrapping add: the carry out of the top bit is dropped.
  assign sum_d = SampleBits'(chan_i + tone_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/note_tone_oscillator.sv =====
// Note tone oscillator top level: voice, two channel lanes and the
// merging output stage. Uses noto_pkg, noto_req_if and noto_smp_if.
//
// Usage: requests arrive on req_i. A start transaction (req_type 1) picks
// the phase step for its note, sets the amplitude from the volume
// (saturated to 100) and clears the phase; a stop transaction (2) mutes
// the tone; code 3 is ignored. Neither gives a sample. A tick transaction
// (0) gives exactly one sample on smp_o: both channels with the sine
// sample added, or passed through when the tone is off.
// Throughput is one transaction per cycle while req_i.ready is high. The
// phase and sine table read of a tick are registered in the first stage;
// the amplitude multiply and the lane adds then go into the output register.
// When smp_o is stalled the output register holds its sample; the first
// stage still takes one more tick, and req_i.ready falls only when both
// stages are full. Start and stop are taken whenever ready is high.
// After reset the tone is off, the phase is zero, the step is that of
// note 69 and the amplitude that of volume 80; the block is ready at once.
module note_tone_oscillator (
  input  logic       clk_i,
  input  logic       rst_ni,
  noto_req_if.sink   req_i,
  noto_smp_if.source smp_o
);
  import noto_pkg::*;

  logic                         fire;
  logic                         out_adv;
  logic                         s1_load;
  logic                         s1_valid;
  tick_t                        s1_tick;
  logic [2*MagBits-1:0]         prod;
  logic [MagBits-1:0]           mag;
  logic signed [SampleBits-1:0] tone;
  logic                         out_valid_q, out_valid_d;
  logic                         tone_on_q;

  // Handshake chain: the output register frees the first stage.
  assign out_adv     = !out_valid_q || smp_o.ready;
  assign s1_load     = !s1_valid || out_adv;
  assign req_i.ready = s1_load;
  assign fire        = req_i.valid && s1_load;

  noto_voice u_voice (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_type_i (req_i.req_type),
    .note_i     (req_i.note),
    .volume_i   (req_i.volume),
    .left_i     (req_i.in_left),
    .right_i    (req_i.in_right),
    .load_i     (s1_load),
    .valid_o    (s1_valid),
    .tick_o     (s1_tick)
  );

  // Scale the sine magnitude by the amplitude, truncate, apply the sign; an inactive tick gives zero.
  assign prod = (2*MagBits)'(s1_tick.rom) * (2*MagBits)'(s1_tick.amp);
  assign mag  = prod[2*MagBits-1:MagBits];
  always_comb begin
    if (!s1_tick.active) begin
      tone = '0;
    end else if (s1_tick.neg) begin
      tone = -$signed({1'b0, mag});
    end else begin
      tone = $signed({1'b0, mag});
    end
  end

  noto_lane u_lane_left (
    .clk_i  (clk_i),
    .en_i   (out_adv),
    .chan_i (s1_tick.left),
    .tone_i (tone),
    .sum_o  (smp_o.out_left)
  );

  noto_lane u_lane_right (
    .clk_i  (clk_i),
    .en_i   (out_adv),
    .chan_i (s1_tick.right),
    .tone_i (tone),
    .sum_o  (smp_o.out_right)
  );

  // Merging stage: valid and tone flag beside the lane registers.
  assign out_valid_d = out_adv ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      tone_on_q <= s1_tick.active;
    end
  end

  assign smp_o.valid   = out_valid_q;
  assign smp_o.tone_on = tone_on_q;

  // A waiting tick in the first stage is kept while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !out_adv |=> s1_valid)
    else $error("tick lost from the first stage during a stall");

  // Requests are refused only when both stages hold a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> s1_valid && out_valid_q)
    else $error("request refused with a free stage");

endmodule

// ===== tb/tb_note_tone_oscillator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the note tone oscillator: directed and random
// request streams, with a built-in predictor of the mixed samples.
// Depends on noto_pkg, noto_req_if, noto_smp_if and note_tone_oscillator.
module tb_note_tone_oscillator;
  import noto_pkg::*;

  // Request code that the block must ignore.
  localparam logic [1:0] ReqUnused = 2'd3;

  // Tone synthesis constants.
  localparam logic [63:0] QOne      = 64'd1073741824;
  localparam logic [63:0] SinCoef1  = 64'd1686629713;
  localparam logic [63:0] SinCoef3  = 64'd693598669;
  localparam logic [63:0] SinCoef5  = 64'd85569305;
  localparam logic [63:0] SinCoef7  = 64'd4858525;
  localparam logic [63:0] Q15Max    = 64'd32767;
  localparam int          VolCeil   = 100;
  localparam int          AmpPerVol = 200;
  localparam int          AmpAtReset  = 16000;
  localparam logic [6:0]  NoteAtReset = 7'd69;

  // Frequencies of the lowest octave, Hz scaled by 2^24.
  localparam logic [63:0] LowOctaveHz [12] = '{
    64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
    64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
    64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
  };

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic signed [SampleBits-1:0] left;
    logic signed [SampleBits-1:0] right;
    logic                         tone_on;
  } mix_t;

  logic clk_i;
  logic rst_ni;

  noto_req_if req_bus ();
  noto_smp_if smp_bus ();

  note_tone_oscillator uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .smp_o (smp_bus)
  );

  // Predicted oscillator state.
  logic [PhaseBits-1:0] model_phase;
  logic [PhaseBits-1:0] tone_step;
  logic [AmpBits-1:0]   tone_amp;
  logic                 tone_live;

  mix_t mix_queue[$];
  int   errors;
  bit   steady;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Rounded phase increment of a note on the equal-tempered scale.
  function automatic logic [PhaseBits-1:0] note_step(logic [6:0] note);
    int          oct;
    int          semi;
    int          sh;
    logic [63:0] base;
    logic [63:0] den;
    logic [63:0] inc;
    oct  = note / 12;
    semi = note % 12;
    sh   = oct + PhaseBits - 24;
    base = LowOctaveHz[semi];
    if (sh >= 0) begin
      inc = ((base << sh) + 64'(SampleRate / 2)) / 64'(SampleRate);
    end else begin
      den = 64'(SampleRate) << (-sh);
      inc = (base + (den >> 1)) / den;
    end
    return inc[PhaseBits-1:0];
  endfunction

  // Signed tone sample at a phase, as a 16-bit pattern.
  function automatic logic [SampleBits-1:0] tone_sample(logic [PhaseBits-1:0] phase,
                                                        logic [AmpBits-1:0] amp);
    logic [63:0] idx;
    logic [63:0] q4;
    logic [63:0] rem;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] mag_rom;
    logic [63:0] mag;
    logic [1:0]  quad;
    idx  = (64'(phase) * 64'(SineEntries)) >> PhaseBits;
    q4   = 64'd4 * idx;
    quad = 2'(q4 / 64'(SineEntries));
    rem  = q4 % 64'(SineEntries);
    t    = (rem << 30) / 64'(SineEntries);
    // Odd quadrants run the quarter wave backwards.
    if (quad[0]) begin
      t = QOne - t;
    end
    t2 = (t * t) >> 30;
    p  = SinCoef7;
    p  = SinCoef5 - ((p * t2) >> 30);
    p  = SinCoef3 - ((p * t2) >> 30);
    p  = SinCoef1 - ((p * t2) >> 30);
    s  = (p * t) >> 30;
    mag_rom = (s * Q15Max) >> 30;
    if (mag_rom > Q15Max) begin
      mag_rom = Q15Max;
    end
    mag = (mag_rom * 64'(amp)) >> 15;
    // The second half of the turn is negative.
    if (quad[1]) begin
      return SampleBits'(64'd0 - mag);
    end
    return mag[SampleBits-1:0];
  endfunction

  // Applies one accepted request to the predicted state.
  task automatic predict_request(logic [1:0] kind, logic [6:0] note, logic [6:0] vol,
                                 logic [15:0] left, logic [15:0] right);
    logic [SampleBits-1:0] add;
    mix_t                  mix;
    case (kind)
      ReqStart: begin
        tone_live   = 1'b1;
        tone_step   = note_step(note);
        tone_amp    = AmpBits'(((vol > VolCeil) ? VolCeil : int'(vol)) * AmpPerVol);
        model_phase = '0;
      end
      ReqStop: begin
        tone_live = 1'b0;
      end
      ReqTick: begin
        add         = tone_live ? tone_sample(model_phase, tone_amp) : '0;
        mix.left    = left + add;
        mix.right   = right + add;
        mix.tone_on = tone_live;
        mix_queue.push_back(mix);
        if (tone_live) begin
          model_phase = model_phase + tone_step;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Sends one request transaction, with random idle cycles ahead of it unless steady is set.
  task automatic send_req(logic [1:0] kind, logic [6:0] note, logic [6:0] vol,
                          logic [15:0] left, logic [15:0] right);
    while (!steady && $urandom_range(99) < 18) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.note     <= note;
    req_bus.volume   <= vol;
    req_bus.in_left  <= left;
    req_bus.in_right <= right;
    do begin
      @(posedge clk_i);
    end while (!req_bus.ready);
    predict_request(kind, note, vol, left, right);
  endtask

  // Tone off: samples pass through, stop and the unused code do nothing.
  task automatic test_passthrough();
    send_req(ReqTick, 7'd0, 7'd0, 16'h8000, 16'h7fff);
    send_req(ReqTick, 7'd127, 7'd127, 16'h7fff, 16'h8000);
    send_req(ReqStop, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_req(ReqUnused, 7'd69, 7'd100, 16'hffff, 16'hffff);
    send_req(ReqTick, 7'd0, 7'd0, 16'hffff, 16'h0000);
  endtask

  // Start at the extremes of note and volume, restart, stop, and wrap-around.
  task automatic test_tone_directed();
    send_req(ReqStart, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_req(ReqTick, 7'd0, 7'd0, 16'h1234, 16'hedcb);
    send_req(ReqTick, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_req(ReqStart, 7'd127, 7'd127, 16'h0000, 16'h0000);
    for (int i = 0; i < 5; i++) begin
      send_req(ReqTick, 7'd0, 7'd0, 16'h7fff, 16'h8000);
    end
    // Restart while running, with volume exactly at the ceiling.
    send_req(ReqStart, 7'd69, 7'd100, 16'h0000, 16'h0000);
    send_req(ReqTick, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_req(ReqTick, 7'd0, 7'd0, 16'h7fff, 16'h7fff);
    send_req(ReqUnused, 7'd5, 7'd5, 16'h0000, 16'h0000);
    send_req(ReqTick, 7'd0, 7'd0, 16'h8000, 16'h8000);
    // Stop keeps the phase; a second stop while idle has no effect.
    send_req(ReqStop, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_req(ReqTick, 7'd0, 7'd0, 16'h0101, 16'h0202);
    send_req(ReqStop, 7'd0, 7'd0, 16'h0000, 16'h0000);
    send_req(ReqTick, 7'd0, 7'd0, 16'h0303, 16'h0404);
    send_req(ReqStart, 7'd101, 7'd101, 16'h0000, 16'h0000);
  endtask

  // Mostly ticks with random content, broken up by start, stop and unused codes.
  task automatic test_random_mix(int count, bit no_idle);
    int roll;
    steady = no_idle;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 84) begin
        send_req(ReqTick, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
      end else if (roll < 91) begin
        send_req(ReqStart, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
      end else if (roll < 97) begin
        send_req(ReqStop, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_req(ReqUnused, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Sample checker and output back-pressure.
  initial begin
    mix_t want;
    smp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (smp_bus.valid && smp_bus.ready) begin
        if (mix_queue.size() == 0) begin
          $error("unexpected sample: left %0d right %0d", smp_bus.out_left,
                 smp_bus.out_right);
          errors++;
        end else begin
          want = mix_queue.pop_front();
          if (smp_bus.out_left !== want.left) begin
            $error("out_left: expected %0d, got %0d", want.left, smp_bus.out_left);
            errors++;
          end
          if (smp_bus.out_right !== want.right) begin
            $error("out_right: expected %0d, got %0d", want.right, smp_bus.out_right);
            errors++;
          end
          if (smp_bus.tone_on !== want.tone_on) begin
            $error("tone_on: expected %0d, got %0d", want.tone_on, smp_bus.tone_on);
            errors++;
          end
        end
      end
      smp_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    int stuck;
    stuck = 0;
    @(posedge rst_ni);
    while (stuck < StallLimit) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (smp_bus.valid && smp_bus.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, test sequence and final verdict.
  initial begin
    errors           = 0;
    steady           = 1'b0;
    rst_ni           = 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= ReqTick;
    req_bus.note     <= '0;
    req_bus.volume   <= '0;
    req_bus.in_left  <= '0;
    req_bus.in_right <= '0;
    model_phase = '0;
    tone_live   = 1'b0;
    tone_step   = note_step(NoteAtReset);
    tone_amp    = AmpBits'(AmpAtReset);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_tone_directed();
    test_random_mix(200, 1'b1);
    test_random_mix(500, 1'b0);
    req_bus.valid <= 1'b0;

    while (mix_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
